// ===== src/incoming_packet_deframer_top_assert.svh =====
// Assertion macros for the incoming packet deframer
`ifndef INCOMING_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define INCOMING_PACKET_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ipd: assertion failed");
// next-cycle implication
`define IPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ipd: assertion failed");
`else
`define IPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ipd_pkg.sv =====
// Types and constants shared by the incoming packet deframer modules
package ipd_pkg;

	localparam int PACKET_WORDS = 32;
	localparam int IDX_W        = $clog2(PACKET_WORDS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_WORDS - 1);

	// word positions that are captured
	localparam logic [IDX_W-1:0] IDX_START  = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_SYSTEM = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_PAIR   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_ENC    = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_ADC_A  = IDX_W'(7);
	localparam logic [IDX_W-1:0] IDX_ADC_B  = IDX_W'(8);

	localparam logic [31:0] START_WORD_RESET = 32'hFEFE_FE01;
	localparam logic [31:0] SUM_INIT         = 32'hFFFF_FFFF;
	localparam int HOME_BIT = 3;

	localparam int OUT_W = 168;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_BAD_SUM   = 2'd1,
		ST_BAD_START = 2'd2
	} status_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] word;
	} word_s1_t;

endpackage

// ===== src/incoming_packet_deframer_top.sv =====
// Top level of the incoming packet deframer
//
//  channel   direction  contents
//  s_*       in         one packet word per transfer
//  m_*       out        status and held fields, one word per packet
//  cfg_*     in         expected start word, write only
//
// A word enters every cycle, limited only by the one-deep result register.
// The result register loads as the final packet word leaves the input register.
// Only the final word of a packet waits while an untaken result blocks the result register.
// Reset zeroes the word counter and held fields, presets the checksum to all ones
// and loads the default start word.
module incoming_packet_deframer_top
	import ipd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] packet_word
	output logic             m_tvalid,
	input  logic             m_tready,
	// [1:0] status, [33:2] system_state, [49:34] pair_state, [65:50] pair_fault,
	// [97:66] encoder_count, [113:98] adc_first, [129:114] adc_second,
	// [145:130] adc_third, [161:146] adc_fourth, [162] home_hit, [167:163] zero
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata
);

	word_s1_t word_s1;
	logic     advance;

	ipd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.word_s1  (word_s1)
	);

	ipd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.word_s1   (word_s1),
		.advance   (advance),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== src/ipd_in_reg.sv =====
// Input register stage of the incoming packet deframer
module ipd_in_reg
	import ipd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] packet_word
	input  logic        advance,
	output word_s1_t    word_s1
);

	logic        valid_s1;
	logic [31:0] data_s1;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	assign word_s1 = '{valid: valid_s1, word: data_s1};

endmodule

// ===== src/ipd_frame.sv =====
// Word counter, checksum, capture, check and result register of the deframer
`include "incoming_packet_deframer_top_assert.svh"

module ipd_frame
	import ipd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  word_s1_t         word_s1,
	output logic             advance,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	logic [31:0]      expected_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      sum_q;
	logic [31:0]      cap_start_q, cap_sys_q, cap_pair_q, cap_enc_q, cap_adca_q, cap_adcb_q;
	logic [31:0]      held_sys_q, held_pair_q, held_enc_q, held_adca_q, held_adcb_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic             is_last;
	logic             finish;
	status_t          status_nx;
	logic             take;
	logic [31:0]      sys_nx, pair_nx, enc_nx, adca_nx, adcb_nx;

	assign is_last = (idx_q == LAST_IDX);
	// non-final words never need the result slot
	assign advance = word_s1.valid && (!is_last || !out_valid_q || m_tready);
	assign finish  = advance && is_last;

	always_comb begin
		if (cap_start_q != expected_q) begin
			status_nx = ST_BAD_START;
		end else if (word_s1.word != sum_q) begin
			status_nx = ST_BAD_SUM;
		end else begin
			status_nx = ST_ACCEPTED;
		end
	end

	assign take    = finish && (status_nx == ST_ACCEPTED);
	assign sys_nx  = take ? cap_sys_q  : held_sys_q;
	assign pair_nx = take ? cap_pair_q : held_pair_q;
	assign enc_nx  = take ? cap_enc_q  : held_enc_q;
	assign adca_nx = take ? cap_adca_q : held_adca_q;
	assign adcb_nx = take ? cap_adcb_q : held_adcb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= START_WORD_RESET;
		end else if (cfg_we) begin
			expected_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sum_q       <= SUM_INIT;
			held_sys_q  <= '0;
			held_pair_q <= '0;
			held_enc_q  <= '0;
			held_adca_q <= '0;
			held_adcb_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (is_last) begin
					idx_q <= '0;
					sum_q <= SUM_INIT;
				end else begin
					idx_q <= idx_q + 1'b1;
					sum_q <= sum_q - word_s1.word;
				end
			end
			held_sys_q  <= sys_nx;
			held_pair_q <= pair_nx;
			held_enc_q  <= enc_nx;
			held_adca_q <= adca_nx;
			held_adcb_q <= adcb_nx;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture registers: each is written before the final word reads it
	always_ff @(posedge clk) begin
		if (advance) begin
			if (idx_q == IDX_START)  cap_start_q <= word_s1.word;
			if (idx_q == IDX_SYSTEM) cap_sys_q   <= word_s1.word;
			if (idx_q == IDX_PAIR)   cap_pair_q  <= word_s1.word;
			if (idx_q == IDX_ENC)    cap_enc_q   <= word_s1.word;
			if (idx_q == IDX_ADC_A)  cap_adca_q  <= word_s1.word;
			if (idx_q == IDX_ADC_B)  cap_adcb_q  <= word_s1.word;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {5'b0,
				~pair_nx[16 + HOME_BIT],
				adcb_nx[15:0], adcb_nx[31:16],
				adca_nx[15:0], adca_nx[31:16],
				enc_nx,
				pair_nx[15:0], pair_nx[31:16],
				sys_nx,
				status_nx};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`IPD_ASSERT_NXT(a_wrap, clk, arst_n, finish, (idx_q == '0) && (sum_q == SUM_INIT))
	`IPD_ASSERT_NXT(a_count, clk, arst_n, advance && !is_last,
		idx_q == $past(idx_q) + 1'b1)
	`IPD_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_valid_q && !m_tready, !finish)
	`IPD_ASSERT_NXT(a_held_load, clk, arst_n, take,
		(held_sys_q == $past(cap_sys_q)) && (held_adcb_q == $past(cap_adcb_q)))

endmodule
